FILE: hw/rtl/ptw4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw4_pkg
// Shared types, codes and helper functions of the four-level page table walker.
// ----------------------------------------------------------------------------
package ptw4_pkg;

   localparam int VA_W    = 48;
   localparam int ROOT_W  = 52;
   localparam int DATA_W  = 64;
   localparam int IDX_W   = 9;
   localparam int PADDR_W = 4;

   // Input item selector carried in tuser.
   localparam logic CMD_TRANSLATE = 1'b0;
   localparam logic CMD_RESPONSE  = 1'b1;

   // Result item kind carried in tuser.
   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // Register index, taken from the eight-byte-aligned word address.
   localparam logic REG_TABLE_ROOT     = 1'b0;
   localparam logic REG_ADDRESS_OFFSET = 1'b1;

   // Walk level codes. Codes five to seven behave as idle.
   localparam logic [2:0] LEVEL_IDLE = 3'd0;
   localparam logic [2:0] LEVEL_1    = 3'd1;
   localparam logic [2:0] LEVEL_2    = 3'd2;
   localparam logic [2:0] LEVEL_3    = 3'd3;
   localparam logic [2:0] LEVEL_4    = 3'd4;

   localparam int LARGE_BIT = 7;

   typedef struct packed {
      logic [ROOT_W-1:0] table_root;
      logic [DATA_W-1:0] address_offset;
   } csr_regs_type;

   typedef struct packed {
      logic              valid;
      logic              kind;
      logic [DATA_W-1:0] read_address;
      logic [DATA_W-1:0] translated_address;
   } step_result_type;

   // Nine-bit table index of a virtual address for a given level.
   function automatic logic [IDX_W-1:0] index_at(input logic [2:0] level,
                                                 input logic [VA_W-1:0] va);
      logic [IDX_W-1:0] idx;
      case (level)
         LEVEL_4: idx = va[47:39];
         LEVEL_3: idx = va[38:30];
         LEVEL_2: idx = va[29:21];
         default: idx = va[20:12];
      endcase
      return idx;
   endfunction

   // Memory address of a table entry: page-aligned base plus offset plus index*8.
   function automatic logic [DATA_W-1:0] entry_address(input logic [DATA_W-1:0] base,
                                                       input logic [DATA_W-1:0] offset,
                                                       input logic [2:0] level,
                                                       input logic [VA_W-1:0] va);
      logic [DATA_W-1:0] aligned;
      logic [DATA_W-1:0] scaled;
      aligned = {base[DATA_W-1:12], 12'h000};
      scaled  = {{(DATA_W-IDX_W-3){1'b0}}, index_at(level, va), 3'b000};
      return aligned + offset + scaled;
   endfunction

endpackage

FILE: hw/rtl/ptw4_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw4_csr
// Register file for the table root and the address offset, on an APB port.
// ----------------------------------------------------------------------------
module ptw4_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [ptw4_pkg::PADDR_W-1:0] csr_paddr,
   input  logic [ptw4_pkg::DATA_W-1:0] csr_pwdata,
   output logic [ptw4_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready,
   output ptw4_pkg::csr_regs_type      regs
);
   import ptw4_pkg::*;

   logic [ROOT_W-1:0] table_root_ff;
   logic [DATA_W-1:0] address_offset_ff;
   logic              write_en;
   logic              reg_sel;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   // Each register occupies an eight-byte word; the byte-lane bits are ignored.
   assign reg_sel    = csr_paddr[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         table_root_ff     <= '0;
         address_offset_ff <= '0;
      end else if (write_en) begin
         if (reg_sel == REG_TABLE_ROOT) begin
            table_root_ff <= csr_pwdata[ROOT_W-1:0];
         end else begin
            address_offset_ff <= csr_pwdata;
         end
      end
   end

   always_comb begin
      if (reg_sel == REG_ADDRESS_OFFSET) begin
         csr_prdata = address_offset_ff;
      end else begin
         csr_prdata = {{(DATA_W-ROOT_W){1'b0}}, table_root_ff};
      end
   end

   assign regs.table_root     = table_root_ff;
   assign regs.address_offset = address_offset_ff;

endmodule

FILE: hw/rtl/ptw4_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw4_walk
// Walk state and the combinational step that handles one request or response.
// ----------------------------------------------------------------------------
module ptw4_walk (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step_en,
   input  logic                        cmd,
   input  logic [ptw4_pkg::VA_W-1:0]   virtual_address,
   input  logic [ptw4_pkg::DATA_W-1:0] read_data,
   input  ptw4_pkg::csr_regs_type      regs,
   output ptw4_pkg::step_result_type   result
);
   import ptw4_pkg::*;

   logic [2:0]        walk_level_ff;
   logic [2:0]        walk_level_in;
   logic [VA_W-1:0]   saved_address_ff;
   logic [VA_W-1:0]   saved_address_in;
   logic              busy;
   logic [DATA_W-1:0] root_base;

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_level_ff    <= LEVEL_IDLE;
         saved_address_ff <= '0;
      end else if (step_en) begin
         walk_level_ff    <= walk_level_in;
         saved_address_ff <= saved_address_in;
      end
   end

   assign busy      = walk_level_ff inside {LEVEL_1, LEVEL_2, LEVEL_3, LEVEL_4};
   assign root_base = {{(DATA_W-ROOT_W){1'b0}}, regs.table_root};

   always_comb begin
      walk_level_in             = walk_level_ff;
      saved_address_in          = saved_address_ff;
      result.valid              = 1'b0;
      result.kind               = KIND_READ;
      result.read_address       = '0;
      result.translated_address = '0;
      if (cmd == CMD_TRANSLATE) begin
         // A request during a walk is dropped.
         if (!busy) begin
            saved_address_in    = virtual_address;
            walk_level_in       = LEVEL_4;
            result.valid        = 1'b1;
            result.read_address = entry_address(root_base, regs.address_offset,
                                                LEVEL_4, virtual_address);
         end
      end else if (!busy) begin
         walk_level_in = LEVEL_IDLE;
      end else if (walk_level_ff == LEVEL_2 && read_data[LARGE_BIT]) begin
         // 2MB page: the entry supplies bits 63..21.
         walk_level_in             = LEVEL_IDLE;
         result.valid              = 1'b1;
         result.kind               = KIND_DONE;
         result.translated_address = {read_data[DATA_W-1:21], saved_address_ff[20:0]};
      end else if (walk_level_ff == LEVEL_1) begin
         walk_level_in             = LEVEL_IDLE;
         result.valid              = 1'b1;
         result.kind               = KIND_DONE;
         result.translated_address = {read_data[DATA_W-1:12], saved_address_ff[11:0]};
      end else begin
         walk_level_in       = walk_level_ff - 3'd1;
         result.valid        = 1'b1;
         result.read_address = entry_address(read_data, regs.address_offset,
                                             walk_level_in, saved_address_ff);
      end
   end

endmodule

FILE: hw/rtl/page_table_walker_4level_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_walker_4level_top
// Four-level page table walker: turns translate requests and returned table
// entries into memory read addresses and finished physical addresses.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Content
// req_*    in         tuser = cmd, tdata = virtual_address, read_data
// rsp_*    out        tuser = kind, tdata = read_address, translated_address
// csr_*    in/out     APB registers: table_root at 0x0, address_offset at 0x8
//
// One transaction is taken every cycle while req_tready is high. Each accepted
// transaction is captured in an input register, handled by the walk step (one
// 64-bit three-input add and a level compare), and its result, if any, is held
// in the output register, which drives rsp_tvalid. Reset is synchronous and
// clears the walk to idle, the CSRs to zero and both registers to empty.
// A stalled output holds its result; the input register still takes one more
// transaction, and req_tready drops only while both registers are full.
// ----------------------------------------------------------------------------
module page_table_walker_4level_top (
   input  logic                         clock,
   input  logic                         reset,
   // Input stream.
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // Bits 47:0 virtual_address, bits 111:48 read_data.
   input  logic [111:0]                 req_tdata,
   // Bit 0 cmd.
   input  logic                         req_tuser,
   // Result stream.
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // Bits 63:0 read_address, bits 127:64 translated_address.
   output logic [127:0]                 rsp_tdata,
   // Bit 0 kind.
   output logic                         rsp_tuser,
   // Configuration port.
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [ptw4_pkg::PADDR_W-1:0] csr_paddr,
   input  logic [ptw4_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [ptw4_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import ptw4_pkg::*;

   csr_regs_type    regs;
   step_result_type result;

   // Input register.
   logic              in_valid_ff;
   logic              in_cmd_ff;
   logic [VA_W-1:0]   in_va_ff;
   logic [DATA_W-1:0] in_data_ff;

   // Output register.
   logic              out_valid_ff;
   logic              out_kind_ff;
   logic [DATA_W-1:0] out_read_ff;
   logic [DATA_W-1:0] out_trans_ff;

   logic out_free;
   logic step_en;
   logic req_accept;

   ptw4_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .regs        (regs)
   );

   // The output register can take a new result when empty or being drained.
   assign out_free   = !out_valid_ff || rsp_tready;
   // The held transaction is processed only when its result has somewhere to go.
   assign step_en    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || step_en;
   assign req_accept = req_tvalid && req_tready;

   ptw4_walk u_walk (
      .clock           (clock),
      .reset           (reset),
      .step_en         (step_en),
      .cmd             (in_cmd_ff),
      .virtual_address (in_va_ff),
      .read_data       (in_data_ff),
      .regs            (regs),
      .result          (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_cmd_ff  <= req_tuser;
         in_va_ff   <= req_tdata[VA_W-1:0];
         in_data_ff <= req_tdata[VA_W+DATA_W-1:VA_W];
      end
   end

   // A step that yields no result leaves the output register empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= step_en && result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && step_en && result.valid) begin
         out_kind_ff  <= result.kind;
         out_read_ff  <= result.read_address;
         out_trans_ff <= result.translated_address;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {out_trans_ff, out_read_ff};

endmodule
